// ===== design/dhtfx_pkg.sv =====
// ----------------------------------------------------------------------------
// dhtfx_pkg
// Shared types, key table and helper functions of the DHT field extractor.
// ----------------------------------------------------------------------------
package dhtfx_pkg;

  localparam int NumKeys  = 9;
  localparam int KeyChars = 16;
  localparam int AccW     = 17;
  localparam int IdxW     = 10;
  localparam int PortW    = 16;
  localparam int ProgW    = 5;

  localparam logic [AccW-1:0] AccSat     = 17'h1FFFF;
  localparam logic [AccW-1:0] PortLimit  = 17'h10000;
  localparam logic [AccW-1:0] FixedLen   = 17'd20;
  localparam logic [IdxW-1:0] LenLimit   = 10'd1023;

  // result kinds
  localparam logic [1:0] KindField   = 2'd0;
  localparam logic [1:0] KindPort    = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // key handling classes
  localparam logic [1:0] ClsLen   = 2'd0;
  localparam logic [1:0] ClsFixed = 2'd1;
  localparam logic [1:0] ClsPort  = 2'd2;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChE     = 8'h65;

  localparam logic [KeyChars*8-1:0] KeyStr [NumKeys] = '{
    "1:t", "2:id20:", "9:info\137hash20:", "4:porti", "12:implied_porti",
    "6:target20:", "5:token", "5:nodes", "6:nodes6"};
  localparam int KeyLen [NumKeys] = '{3, 7, 14, 7, 16, 11, 7, 7, 8};
  localparam logic [1:0] KeyCls [NumKeys] = '{
    ClsLen, ClsFixed, ClsFixed, ClsPort, ClsPort,
    ClsFixed, ClsLen, ClsLen, ClsLen};

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_DIGITS = 2'd1,
    PH_COPY   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic             emit;
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  flen;
    logic [PortW-1:0] port;
  } key_res_t;

  typedef struct packed {
    key_res_t [NumKeys-1:0] res;
    logic     [7:0]         data;
    logic                   eom;
  } bundle_t;

  // character i of key m
  function automatic logic [7:0] key_char(input int m, input int i);
    logic [KeyChars*8-1:0] s;
    s = KeyStr[m];
    if (i < 0 || i >= KeyLen[m]) return 8'h00;
    return s[(KeyLen[m]-1-i)*8 +: 8];
  endfunction

  // with p chars matched, key[0..k-2] equals the tail key[p-k+1..p-1]
  function automatic logic border_ok(input int m, input int p, input int k);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < KeyChars; j++) begin
      if (j + 1 < k && key_char(m, j) != key_char(m, p - k + 1 + j)) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== design/dhtfx_matcher.sv =====
// ----------------------------------------------------------------------------
// dhtfx_matcher
// One key matcher: key search, decimal value read, and byte copy tagging.
// ----------------------------------------------------------------------------
module dhtfx_matcher import dhtfx_pkg::*; #(
  parameter int M     = 0,
  parameter int BOUND = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_i,
  input  logic       eom_i,
  output key_res_t   res_o
);

  localparam int Len = KeyLen[M];
  localparam logic [1:0] Cls = KeyCls[M];
  localparam logic [AccW-1:0] Bound = AccW'(BOUND);

  phase_e            phase_q, phase_d;
  logic [ProgW-1:0]  prog_q, prog_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;

  logic [ProgW-1:0]  p_eff, adv;
  logic [AccW+3:0]   prod;
  logic [IdxW-1:0]   cnt_inc;
  logic              is_digit, len_ok;

  // substring search step with fallback
  always_comb begin
    p_eff = (prog_q >= ProgW'(Len)) ? '0 : prog_q;
    adv   = '0;
    for (int p = 0; p < Len; p++) begin
      if (p_eff == ProgW'(p)) begin
        for (int k = 1; k <= p + 1; k++) begin
          if (key_char(M, k-1) == data_i && border_ok(M, p, k)) adv = ProgW'(k);
        end
      end
    end
  end

  // digit accumulate and bound checks
  assign is_digit = (data_i >= ChZero) && (data_i <= ChNine);
  assign prod     = (AccW+4)'(acc_q) * (AccW+4)'(10) + (AccW+4)'(data_i - ChZero);
  assign len_ok   = (acc_q != '0) && (acc_q <= Bound) && (acc_q <= AccW'(LenLimit));
  assign cnt_inc  = cnt_q + 1'b1;

  // next state and emitted result
  always_comb begin
    phase_d = phase_q;
    prog_d  = prog_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    res_o   = '0;
    case (phase_q)
      PH_SEARCH: begin
        prog_d = adv;
        if (adv == ProgW'(Len)) begin
          cnt_d = '0;
          if (Cls == ClsFixed) begin
            acc_d   = FixedLen;
            phase_d = PH_COPY;
          end else begin
            acc_d   = '0;
            phase_d = PH_DIGITS;
          end
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_d = (prod > (AccW+4)'(AccSat)) ? AccSat : prod[AccW-1:0];
        end else if (Cls == ClsPort) begin
          if (data_i == ChE && acc_q != '0 && acc_q < PortLimit) begin
            res_o.emit = 1'b1;
            res_o.port = acc_q[PortW-1:0];
          end
          phase_d = PH_DONE;
        end else if (data_i == ChColon && len_ok) begin
          cnt_d   = '0;
          phase_d = PH_COPY;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_COPY: begin
        res_o.emit = 1'b1;
        res_o.idx  = cnt_q;
        res_o.flen = acc_q[IdxW-1:0];
        cnt_d      = cnt_inc;
        if (AccW'(cnt_inc) >= acc_q || cnt_inc == '0) phase_d = PH_DONE;
      end
      default: phase_d = PH_DONE;
    endcase
    if (eom_i) begin
      phase_d = PH_SEARCH;
      prog_d  = '0;
      acc_d   = '0;
      cnt_d   = '0;
    end
  end

  // matcher state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      prog_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prog_q  <= prog_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/dhtfx_emitter.sv =====
// ----------------------------------------------------------------------------
// dhtfx_emitter
// Queue of per-byte result bundles, serialized one result word per cycle while the output is ready.
// ----------------------------------------------------------------------------
module dhtfx_emitter import dhtfx_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bundle_t     bundle_i,
  output logic        full_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,
  output logic [5:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SelW = NumKeys + 1;
  localparam int SelIdxW = $clog2(SelW);

  bundle_t             mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic [SelW-1:0]     sent_q;
  logic                empty, load, pop;
  bundle_t             head;
  logic [SelW-1:0]     pend, pick, rest;
  logic [SelIdxW-1:0]  sel;

  logic              vld_q;
  logic [1:0]        kind_q;
  logic [3:0]        tag_q;
  logic [IdxW-1:0]   idx_q, flen_q;
  logic [7:0]        byte_q;
  logic [PortW-1:0]  port_q;
  logic              ok_q, last_q;

  assign empty  = (cnt_q == '0);
  assign full_o = (cnt_q == CntW'(DEPTH));
  assign head   = mem_q[rd_q];
  assign load   = !empty && (!vld_q || m_axis_tready_i);

  // pick the lowest pending result of the head bundle
  always_comb begin
    for (int i = 0; i < NumKeys; i++) pend[i] = head.res[i].emit;
    pend[NumKeys] = head.eom;
    pend = pend & ~sent_q;
    sel  = '0;
    for (int i = SelW-1; i >= 0; i--) begin
      if (pend[i]) sel = SelIdxW'(i);
    end
    pick      = '0;
    pick[sel] = 1'b1;
    rest      = pend & ~pick;
  end

  assign pop = load && (rest == '0);

  // bundle storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

  // queue pointers and progress through the head bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      sent_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PtrW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop);
      if (pop) sent_q <= '0;
      else if (load) sent_q <= sent_q | pick;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= (rest == '0);
      kind_q <= KindField;
      tag_q  <= 4'(sel);
      idx_q  <= '0;
      flen_q <= '0;
      byte_q <= '0;
      port_q <= '0;
      ok_q   <= 1'b0;
      if (sel == NumKeys) begin
        kind_q <= KindSummary;
        tag_q  <= '0;
        ok_q   <= (head.data == 8'h00);
      end else if (KeyCls[sel] == ClsPort) begin
        kind_q <= KindPort;
        port_q <= head.res[sel].port;
      end else begin
        idx_q  <= head.res[sel].idx;
        flen_q <= head.res[sel].flen;
        byte_q <= head.data;
      end
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = {tag_q, kind_q};
  assign m_axis_tdata_o  = {3'b000, ok_q, flen_q, port_q, byte_q, idx_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH)) else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> pend != '0) else $error("queued bundle with nothing to send");
  a_sent_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> sent_q == '0) else $error("progress mask not cleared on pop");
`endif

endmodule

// ===== design/dht_message_field_extractor.sv =====
// ----------------------------------------------------------------------------
// dht_message_field_extractor
// Extracts tid, id, info hash, port, target, token and node fields of a
// bencoded DHT message.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while the queue is not full. Nine key
// matchers look at every byte in the cycle after it is registered; the
// results each byte causes are put as one bundle into a small queue, and one
// result word per cycle leaves the output register while the output is ready.
// Input throughput is one byte per cycle as long as the average result count
// stays at or below one per byte; a byte causes at most ten words (nine field
// results and the end summary), and the queue of FIFO_DEPTH bundles absorbs
// bursts of overlapping captures. The first result word of a byte passes the
// input register, the bundle queue and the output word register.
module dht_message_field_extractor import dhtfx_pkg::*; #(
  parameter int TID_MAX    = 16,
  parameter int TOKEN_MAX  = 128,
  parameter int NODES_MAX  = 416,
  parameter int NODES6_MAX = 608,
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // data_byte
  input  logic        s_axis_tlast_i,  // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // byte_index[9:0], field_byte[17:10], port_value[33:18],
  // field_length[43:34], message_ok[44], zero fill
  output logic [47:0] m_axis_tdata_o,
  output logic [5:0]  m_axis_tuser_o,  // result_kind[1:0], field_tag[5:2]
  output logic        m_axis_tlast_o   // last_result
);

  logic       in_vld_q;
  logic [7:0] in_data_q;
  logic       in_eom_q;
  logic       full, step;
  bundle_t    bundle;
  logic       any_emit;

  assign step            = in_vld_q && !full;
  assign s_axis_tready_o = !in_vld_q || !full;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_eom_q  <= s_axis_tlast_i;
    end
  end

  // key matchers
  for (genvar g = 0; g < NumKeys; g++) begin : g_key
    localparam int Bnd = (g == 0) ? TID_MAX - 1 :
                         (g == 6) ? TOKEN_MAX - 1 :
                         (g == 7) ? NODES_MAX :
                         (g == 8) ? NODES6_MAX : 0;
    dhtfx_matcher #(.M(g), .BOUND(Bnd)) u_match (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .data_i (in_data_q),
      .eom_i  (in_eom_q),
      .res_o  (bundle.res[g])
    );
  end

  assign bundle.data = in_data_q;
  assign bundle.eom  = in_eom_q;

  // only bundles that produce output are queued
  always_comb begin
    any_emit = in_eom_q;
    for (int i = 0; i < NumKeys; i++) any_emit = any_emit | bundle.res[i].emit;
  end

  dhtfx_emitter #(.DEPTH(FIFO_DEPTH)) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (step && any_emit),
    .bundle_i        (bundle),
    .full_o          (full),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
